// ===== design/cdsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and step functions for the clock divider source picker.
// No dependencies; imported by clock_divider_source_picker and its test bench.
package cdsp_pkg;

   // Field widths
   localparam int SRC_COUNT = 4;
   localparam int LANE_W    = 2;
   localparam int REQ_W     = 30;
   localparam int DIVI_W    = 12;
   localparam int DIVF_W    = 10;
   localparam int DIV_W     = DIVI_W + DIVF_W;
   localparam int ACH_W     = 37;
   localparam int ERR_W     = REQ_W + 8;
   localparam int CODE_W    = 3;
   localparam int LIM_W     = REQ_W + DIVI_W;

   // Dividends are source * 2^10 (divisor) and source * 2^18 (achieved frequency)
   localparam int N1_W = REQ_W + DIVF_W;
   localparam int N2_W = REQ_W + 18;

   // Restoring divider schedule: quotient bits and bits retired per stage
   localparam int D1_STEPS  = DIV_W;
   localparam int D2_STEPS  = ACH_W;
   localparam int STEP_BITS = 2;
   localparam int NS1       = (D1_STEPS + STEP_BITS - 1) / STEP_BITS;
   localparam int NS2       = (D2_STEPS + STEP_BITS - 1) / STEP_BITS;
   localparam int BIT_IDX_W = 6;

   localparam logic [DIVI_W-1:0] DIVI_MIN  = 12'd2;
   localparam logic [ERR_W-1:0]  ERR_BOUND = 38'd256000000000;

   // Hardware clock source codes
   localparam logic [CODE_W-1:0] SRC_CODE_1000M = 3'd5;
   localparam logic [CODE_W-1:0] SRC_CODE_500M  = 3'd6;
   localparam logic [CODE_W-1:0] SRC_CODE_216M  = 3'd7;
   localparam logic [CODE_W-1:0] SRC_CODE_19M2  = 3'd1;

   // Sources in priority order
   localparam logic [REQ_W-1:0] SRC_HZ [SRC_COUNT] = '{
      30'd1000000000, 30'd500000000, 30'd216000000, 30'd19200000
   };
   localparam logic [CODE_W-1:0] SRC_CODE [SRC_COUNT] = '{
      SRC_CODE_1000M, SRC_CODE_500M, SRC_CODE_216M, SRC_CODE_19M2
   };

   typedef struct packed {
      logic                 valid;
      logic [REQ_W-1:0]     req;
      logic [SRC_COUNT-1:0] usable;
   } ctl_type;

   typedef struct packed {
      logic [REQ_W-1:0] rem;
      logic [DIV_W-1:0] quo;
   } d1_lane_type;

   typedef struct packed {
      logic [DIV_W-1:0] den;
      logic [DIV_W-1:0] rem;
      logic [ACH_W-1:0] quo;
   } d2_lane_type;

   typedef struct packed {
      logic [ERR_W-1:0] err;
      logic [DIV_W-1:0] den;
      logic [ACH_W-1:0] ach;
   } e_lane_type;

   typedef struct packed {
      logic              ok;
      logic [LANE_W-1:0] idx;
      e_lane_type        lane;
   } cand_type;

   typedef struct packed {
      logic              found;
      logic [CODE_W-1:0] source_number;
      logic [DIVI_W-1:0] divisor_integer;
      logic [DIVF_W-1:0] divisor_fraction;
      logic [ACH_W-1:0]  achieved_freq_q8;
   } rsp_type;

   // Bit of source * 2^10
   function automatic logic n1_bit(input logic [LANE_W-1:0] lane,
                                   input logic [BIT_IDX_W-1:0] idx);
      logic [N1_W-1:0] n;
      n = {SRC_HZ[lane], 10'd0};
      return n[idx];
   endfunction

   // Bits of source * 2^10 above the quotient range: the starting remainder
   function automatic logic [REQ_W-1:0] n1_top(input logic [LANE_W-1:0] lane);
      logic [N1_W-1:0] n;
      n = {SRC_HZ[lane], 10'd0};
      return REQ_W'(n[N1_W-1:D1_STEPS]);
   endfunction

   // Bit of source * 2^18
   function automatic logic n2_bit(input logic [LANE_W-1:0] lane,
                                   input logic [BIT_IDX_W-1:0] idx);
      logic [N2_W-1:0] n;
      n = {SRC_HZ[lane], 18'd0};
      return n[idx];
   endfunction

   function automatic logic [DIV_W-1:0] n2_top(input logic [LANE_W-1:0] lane);
      logic [N2_W-1:0] n;
      n = {SRC_HZ[lane], 18'd0};
      return DIV_W'(n[N2_W-1:D2_STEPS]);
   endfunction

   // One restoring step: returns {quotient bit, new remainder}
   function automatic logic [REQ_W:0] div1_step(input logic [REQ_W-1:0] rem,
                                                input logic [REQ_W-1:0] den,
                                                input logic b);
      logic [REQ_W:0] sh;
      logic [REQ_W:0] diff;
      sh   = {rem, b};
      diff = sh - {1'b0, den};
      if (sh >= {1'b0, den}) begin
         return {1'b1, diff[REQ_W-1:0]};
      end
      return {1'b0, sh[REQ_W-1:0]};
   endfunction

   function automatic logic [DIV_W:0] div2_step(input logic [DIV_W-1:0] rem,
                                                input logic [DIV_W-1:0] den,
                                                input logic b);
      logic [DIV_W:0] sh;
      logic [DIV_W:0] diff;
      sh   = {rem, b};
      diff = sh - {1'b0, den};
      if (sh >= {1'b0, den}) begin
         return {1'b1, diff[DIV_W-1:0]};
      end
      return {1'b0, sh[DIV_W-1:0]};
   endfunction

endpackage

// ===== design/clock_divider_source_picker.sv =====
`timescale 1ns / 1ps
// Clock divider source picker: top level with the full pipelined datapath.
// Depends on cdsp_pkg for types, source table and divider step functions.

// Takes one requested frequency per cycle and returns the best of
// four fixed sources (1000, 500, 216, 19.2 MHz) with its Q12.10 divisor and the
// achieved frequency in Q8 Hz. Each source has its own lane: a restoring divider
// retiring two quotient bits per stage forms the divisor (11 stages), a second one
// forms the achieved frequency (19 stages), then the error is taken and a two-level
// tree picks the smallest error, ties going to the earlier source. Throughput is one
// item per cycle while the skid register is empty. An output register and the
// one-item skid register decouple the result side, so a stalled result does not
// block the next accepted item.
module clock_divider_source_picker
   import cdsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [29:0] requested_hz, [31:30] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [0] found, [3:1] source_number,
                                    // [15:4] divisor_integer, [25:16] divisor_fraction,
                                    // [62:26] achieved_freq_q8, [63] zero
);

   logic adv;

   logic             s0_valid_ff;
   logic [REQ_W-1:0] s0_req_ff;

   logic [LIM_W-1:0]     req_lim;
   logic [SRC_COUNT-1:0] usable0;

   ctl_type     d1_ctl_in  [NS1+1];
   ctl_type     d1_ctl_ff  [NS1+1];
   d1_lane_type d1_lane_in [NS1+1][SRC_COUNT];
   d1_lane_type d1_lane_ff [NS1+1][SRC_COUNT];

   ctl_type     d2_ctl_in  [NS2+1];
   ctl_type     d2_ctl_ff  [NS2+1];
   d2_lane_type d2_lane_in [NS2+1][SRC_COUNT];
   d2_lane_type d2_lane_ff [NS2+1][SRC_COUNT];

   logic                 e_valid_ff;
   logic [SRC_COUNT-1:0] e_usable_ff;
   e_lane_type           e_lane_in [SRC_COUNT];
   e_lane_type           e_lane_ff [SRC_COUNT];

   logic     m_valid_ff;
   cand_type m_cand_in [2];
   cand_type m_cand_ff [2];

   cand_type fin;
   rsp_type  fin_rsp;

   logic    out_take;
   logic    out_valid_in, out_valid_ff;
   logic    skid_valid_in, skid_valid_ff;
   rsp_type out_in, out_ff;
   rsp_type skid_in, skid_ff;

   // Later candidate wins only when it is ok and the earlier one is not ok or has a larger error
   function automatic cand_type pick(input cand_type a, input cand_type b);
      if (b.ok && (!a.ok || (b.lane.err < a.lane.err))) begin
         return b;
      end
      return a;
   endfunction

   // Advance the whole pipeline while the skid register is free
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   // Capture the request
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_req_ff <= req_tdata[REQ_W-1:0];
      end
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   // Range check: 2*req <= source <= 4095*req, with 4095*req as (req << 12) - req
   assign req_lim = {s0_req_ff, 12'd0} - LIM_W'(s0_req_ff);
   assign d1_ctl_in[0] = '{valid: s0_valid_ff, req: s0_req_ff, usable: usable0};

   for (genvar l = 0; l < SRC_COUNT; l++) begin : g_init1
      assign usable0[l] = ({1'b0, SRC_HZ[l]} >= {s0_req_ff, 1'b0}) &&
                          (LIM_W'(SRC_HZ[l]) <= req_lim);
      always_comb begin
         d1_lane_in[0][l] = '{rem: n1_top(LANE_W'(l)), quo: '0};
      end
   end

   // Divisor: source * 1024 / req, two quotient bits per stage
   for (genvar k = 0; k < NS1; k++) begin : g_d1
      assign d1_ctl_in[k+1] = d1_ctl_ff[k];
      for (genvar l = 0; l < SRC_COUNT; l++) begin : g_lane
         always_comb begin
            logic [REQ_W:0] st;
            d1_lane_in[k+1][l] = d1_lane_ff[k][l];
            for (int b = 0; b < STEP_BITS; b++) begin
               if (k * STEP_BITS + b < D1_STEPS) begin
                  st = div1_step(d1_lane_in[k+1][l].rem, d1_ctl_ff[k].req,
                                 n1_bit(LANE_W'(l),
                                        BIT_IDX_W'(D1_STEPS - 1 - k * STEP_BITS - b)));
                  d1_lane_in[k+1][l].rem = st[REQ_W-1:0];
                  d1_lane_in[k+1][l].quo = {d1_lane_in[k+1][l].quo[DIV_W-2:0], st[REQ_W]};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS1; k++) begin
         if (adv) begin
            d1_ctl_ff[k].req    <= d1_ctl_in[k].req;
            d1_ctl_ff[k].usable <= d1_ctl_in[k].usable;
            for (int l = 0; l < SRC_COUNT; l++) begin
               d1_lane_ff[k][l] <= d1_lane_in[k][l];
            end
         end
         if (reset) begin
            d1_ctl_ff[k].valid <= 1'b0;
         end else if (adv) begin
            d1_ctl_ff[k].valid <= d1_ctl_in[k].valid;
         end
      end
   end

   // Achieved frequency: source * 2^18 / divisor
   assign d2_ctl_in[0] = d1_ctl_ff[NS1];
   for (genvar l = 0; l < SRC_COUNT; l++) begin : g_init2
      always_comb begin
         d2_lane_in[0][l] = '{den: d1_lane_ff[NS1][l].quo,
                              rem: n2_top(LANE_W'(l)), quo: '0};
      end
   end

   for (genvar k = 0; k < NS2; k++) begin : g_d2
      assign d2_ctl_in[k+1] = d2_ctl_ff[k];
      for (genvar l = 0; l < SRC_COUNT; l++) begin : g_lane
         always_comb begin
            logic [DIV_W:0] st;
            d2_lane_in[k+1][l] = d2_lane_ff[k][l];
            for (int b = 0; b < STEP_BITS; b++) begin
               if (k * STEP_BITS + b < D2_STEPS) begin
                  st = div2_step(d2_lane_in[k+1][l].rem, d2_lane_ff[k][l].den,
                                 n2_bit(LANE_W'(l),
                                        BIT_IDX_W'(D2_STEPS - 1 - k * STEP_BITS - b)));
                  d2_lane_in[k+1][l].rem = st[DIV_W-1:0];
                  d2_lane_in[k+1][l].quo = {d2_lane_in[k+1][l].quo[ACH_W-2:0], st[DIV_W]};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS2; k++) begin
         if (adv) begin
            d2_ctl_ff[k].req    <= d2_ctl_in[k].req;
            d2_ctl_ff[k].usable <= d2_ctl_in[k].usable;
            for (int l = 0; l < SRC_COUNT; l++) begin
               d2_lane_ff[k][l] <= d2_lane_in[k][l];
            end
         end
         if (reset) begin
            d2_ctl_ff[k].valid <= 1'b0;
         end else if (adv) begin
            d2_ctl_ff[k].valid <= d2_ctl_in[k].valid;
         end
      end
   end

   // Absolute error against req in Q8
   for (genvar l = 0; l < SRC_COUNT; l++) begin : g_err
      always_comb begin
         logic [ERR_W-1:0] ach;
         logic [ERR_W-1:0] target;
         ach    = ERR_W'(d2_lane_ff[NS2][l].quo);
         target = {d2_ctl_ff[NS2].req, 8'd0};
         e_lane_in[l].err = (ach >= target) ? (ach - target) : (target - ach);
         e_lane_in[l].den = d2_lane_ff[NS2][l].den;
         e_lane_in[l].ach = d2_lane_ff[NS2][l].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_usable_ff <= d2_ctl_ff[NS2].usable;
         for (int l = 0; l < SRC_COUNT; l++) begin
            e_lane_ff[l] <= e_lane_in[l];
         end
      end
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= d2_ctl_ff[NS2].valid;
      end
   end

   // First level of the selection tree: one winner per pair of sources
   for (genvar p = 0; p < 2; p++) begin : g_pair
      always_comb begin
         cand_type ca;
         cand_type cb;
         ca.ok   = e_usable_ff[2*p] && (e_lane_ff[2*p].err < ERR_BOUND);
         ca.idx  = LANE_W'(2*p);
         ca.lane = e_lane_ff[2*p];
         cb.ok   = e_usable_ff[2*p+1] && (e_lane_ff[2*p+1].err < ERR_BOUND);
         cb.idx  = LANE_W'(2*p+1);
         cb.lane = e_lane_ff[2*p+1];
         m_cand_in[p] = pick(ca, cb);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_cand_ff[0] <= m_cand_in[0];
         m_cand_ff[1] <= m_cand_in[1];
      end
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= e_valid_ff;
      end
   end

   // Final pick and result formatting; zero fields when nothing fits
   always_comb begin
      fin     = pick(m_cand_ff[0], m_cand_ff[1]);
      fin_rsp = '0;
      if (fin.ok) begin
         fin_rsp.found            = 1'b1;
         fin_rsp.source_number    = SRC_CODE[fin.idx];
         fin_rsp.divisor_integer  = fin.lane.den[DIV_W-1:DIVF_W];
         fin_rsp.divisor_fraction = fin.lane.den[DIVF_W-1:0];
         fin_rsp.achieved_freq_q8 = fin.lane.ach;
      end
   end

   // Output register with skid: park a result when the output is still held
   assign out_take = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (m_valid_ff) begin
         if (!out_valid_ff || out_take) begin
            out_in       = fin_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = fin_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.achieved_freq_q8, out_ff.divisor_fraction,
                        out_ff.divisor_integer, out_ff.source_number, out_ff.found};

   // A found result carries a real source and a divisor of at least two
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.found |->
         (out_ff.divisor_integer >= DIVI_MIN) && (out_ff.source_number != '0))
      else $error("found result with bad divisor or source");

   // A miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.found |->
         (out_ff.source_number == '0) && (out_ff.divisor_integer == '0) &&
         (out_ff.divisor_fraction == '0) && (out_ff.achieved_freq_q8 == '0))
      else $error("miss result with nonzero fields");

   // The skid register only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid item without output item");

   // A parked item stays put until the output drains
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_tready |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid item lost or changed while stalled");

endmodule

// ===== tb/clock_divider_source_picker_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for clock_divider_source_picker: streams requested frequencies in,
// predicts the chosen source, divisor and achieved frequency, and checks every result item.
// Depends on cdsp_pkg (widths, source codes, result struct) and the block under test.
module clock_divider_source_picker_test;
   import cdsp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned QUIET_TAIL  = 100;   // last items sent with no idling
   localparam int unsigned HOLD_AFTER  = 300;   // items accepted before the long hold-off
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES = 40;   // quiet time after the last result is back
   localparam int unsigned RANDOM_ITEMS = 1000;
   localparam int unsigned REPORT_MAX  = 10;

   localparam longint unsigned RATIO_MIN  = 2;
   localparam longint unsigned RATIO_MAX  = 4095;
   localparam longint unsigned FRAC_SCALE = 1024;
   localparam longint unsigned Q8_SCALE   = 256;
   localparam longint unsigned START_ERR  = 64'd256000000000;

   // Sources in priority order with their hardware codes
   localparam longint unsigned SOURCE_HZ [4] = '{
      64'd1000000000, 64'd500000000, 64'd216000000, 64'd19200000
   };
   localparam logic [CODE_W-1:0] SOURCE_CODE [4] = '{
      SRC_CODE_1000M, SRC_CODE_500M, SRC_CODE_216M, SRC_CODE_19M2
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [29:0] requested_hz, [31:30] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [0] found, [3:1] source_number, [15:4] divisor_integer,
                                   // [25:16] divisor_fraction, [62:26] achieved_freq_q8

   logic [REQ_W-1:0] requests_to_send [$];
   rsp_type          expected_picks [$];

   int unsigned send_gap       = 0;
   int unsigned recv_gap       = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 1'b0;
   int unsigned items_accepted = 0;
   int unsigned failures       = 0;
   int unsigned cycle_count    = 0;

   clock_divider_source_picker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Pick the source with the strictly smallest Q8 error; ties keep the earlier source
   function automatic rsp_type best_source_for(input logic [REQ_W-1:0] hz);
      longint unsigned req, src, div, ach, target, err, best_err;
      rsp_type pick;
      pick     = '0;
      best_err = START_ERR;
      req      = hz;
      if (req != 0) begin
         for (int i = 0; i < 4; i++) begin
            src = SOURCE_HZ[i];
            if (src >= RATIO_MIN * req && src <= RATIO_MAX * req) begin
               div    = (src * FRAC_SCALE) / req;
               ach    = (src * FRAC_SCALE * Q8_SCALE) / div;
               target = req * Q8_SCALE;
               err    = (ach >= target) ? ach - target : target - ach;
               if (err < best_err) begin
                  best_err               = err;
                  pick.found             = 1'b1;
                  pick.source_number     = SOURCE_CODE[i];
                  pick.divisor_integer   = div[21:10];
                  pick.divisor_fraction  = div[9:0];
                  pick.achieved_freq_q8  = ach[36:0];
               end
            end
         end
      end
      return pick;
   endfunction

   // Mostly requests inside the usable span, some around the ratio limits, some anywhere
   function automatic logic [REQ_W-1:0] random_request();
      int unsigned     pick, k, i;
      longint unsigned edge_hz;
      longint signed   val;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         return REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
      end
      if (pick < 35) begin
         i = $urandom_range(0, 3);
         if ($urandom_range(0, 1) == 0) begin
            edge_hz = SOURCE_HZ[i] / RATIO_MIN;
         end else begin
            edge_hz = (SOURCE_HZ[i] + RATIO_MAX - 1) / RATIO_MAX;
         end
         val = longint'(edge_hz) + longint'($urandom_range(0, 6)) - 3;
         return REQ_W'(val);
      end
      k = $urandom_range(12, 28);
      return REQ_W'($urandom_range(1 << k, (2 << k) - 1));
   endfunction

   // Drive request items from the queue, with short random gaps until the tail
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (requests_to_send.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, requests_to_send.pop_front()};
            if (requests_to_send.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
               send_gap <= $urandom_range(1, 3);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Predict the result of every accepted request
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_picks.push_back(best_source_for(req_tdata[REQ_W-1:0]));
         items_accepted <= items_accepted + 1;
      end
   end

   // Hold off the result side once for a long stretch so the pipeline backs up
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!reset && !hold_done && items_accepted >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Stall the result side in short random bursts until the tail
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (recv_gap != 0) begin
         rsp_tready <= 1'b0;
         recv_gap   <= recv_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (requests_to_send.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0) begin
            recv_gap <= $urandom_range(1, 3);
         end
      end
   end

   // Check each result item against the oldest prediction
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found            = rsp_tdata[0];
         got.source_number    = rsp_tdata[3:1];
         got.divisor_integer  = rsp_tdata[15:4];
         got.divisor_fraction = rsp_tdata[25:16];
         got.achieved_freq_q8 = rsp_tdata[62:26];
         if (expected_picks.size() == 0) begin
            failures = failures + 1;
            if (failures <= REPORT_MAX) begin
               $display("unexpected result item: found %0d src %0d div %0d.%0d ach %0d",
                        got.found, got.source_number, got.divisor_integer,
                        got.divisor_fraction, got.achieved_freq_q8);
            end
         end else begin
            want = expected_picks.pop_front();
            if (got.found !== want.found || got.source_number !== want.source_number ||
                got.divisor_integer !== want.divisor_integer ||
                got.divisor_fraction !== want.divisor_fraction ||
                got.achieved_freq_q8 !== want.achieved_freq_q8) begin
               failures = failures + 1;
               if (failures <= REPORT_MAX) begin
                  $display("wrong result: expected found %0d src %0d div %0d.%0d ach %0d",
                           want.found, want.source_number, want.divisor_integer,
                           want.divisor_fraction, want.achieved_freq_q8);
                  $display("              actual   found %0d src %0d div %0d.%0d ach %0d",
                           got.found, got.source_number, got.divisor_integer,
                           got.divisor_fraction, got.achieved_freq_q8);
               end
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("clock_divider_source_picker: mismatch");
         $finish;
      end
   end

   initial begin
      // Zero, field extremes, the edges of each source at the exact ratio of 2 and the nearest
      // ratio of 4095, a tie between sources, and requests no source can serve
      requests_to_send.push_back(REQ_W'(0));
      requests_to_send.push_back(REQ_W'(1));
      requests_to_send.push_back({REQ_W{1'b1}});
      requests_to_send.push_back(REQ_W'(1000000000));
      requests_to_send.push_back(REQ_W'(250000000));
      requests_to_send.push_back(REQ_W'(108000000));
      requests_to_send.push_back(REQ_W'(48000000));
      requests_to_send.push_back(REQ_W'(1000));
      for (int i = 0; i < 4; i++) begin
         requests_to_send.push_back(REQ_W'(SOURCE_HZ[i] / RATIO_MIN));
         requests_to_send.push_back(REQ_W'(SOURCE_HZ[i] / RATIO_MIN + 1));
         requests_to_send.push_back(REQ_W'((SOURCE_HZ[i] + RATIO_MAX - 1) / RATIO_MAX));
         requests_to_send.push_back(REQ_W'((SOURCE_HZ[i] + RATIO_MAX - 1) / RATIO_MAX - 1));
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         requests_to_send.push_back(random_request());
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Drain: all requests taken, all results back, then DRAIN_CYCLES of quiet
      while (requests_to_send.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && expected_picks.size() == 0) begin
         $display("clock_divider_source_picker: match");
      end else begin
         $display("clock_divider_source_picker: mismatch");
      end
      $finish;
   end

endmodule
